FILE: sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the mask bounding box crop block.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CROP_PADDING = 2'd2;

    // register reset values
    localparam logic [10:0] RESET_FRAME_WIDTH  = 11'd160;
    localparam logic [10:0] RESET_FRAME_HEIGHT = 11'd120;
    localparam logic [7:0]  RESET_CROP_PADDING = 8'd30;

    // smallest frame size in effect
    localparam logic [10:0] MIN_FRAME_SIZE = 11'd2;

    // register contents as seen by the pixel tracker
    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [7:0]  crop_padding;
    } cfg_t;

    // finished frame: tracked extremes plus the sizes in effect
    typedef struct packed {
        logic [9:0]  least_col;
        logic [9:0]  greatest_col;
        logic [9:0]  least_row;
        logic [9:0]  greatest_row;
        logic [10:0] size_w;
        logic [10:0] size_h;
        logic [7:0]  pad;
    } frame_rec_t;

    // window along one axis
    typedef struct packed {
        logic [9:0] start;
        logic [9:0] len;
    } axis_t;

endpackage

FILE: sv/bbc_tracker.sv
// ----------------------------------------------------------------------------
// bbc_tracker
// Front part: counts column and row of each accepted pixel, tracks the
// foreground extremes and hands a frame record to the queue at frame end.
// ----------------------------------------------------------------------------
module bbc_tracker #(
    parameter int SIZE_W_TOP = 1024,
    parameter int SIZE_H_TOP = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bbc_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              foreground,
    output logic              rec_valid,
    input  logic              rec_ready,
    output bbc_pkg::frame_rec_t rec
);
    import bbc_pkg::*;

    localparam logic [10:0] W_TOP = 11'(SIZE_W_TOP);
    localparam logic [10:0] H_TOP = 11'(SIZE_H_TOP);

    logic [9:0]  col_reg, col_next;
    logic [9:0]  row_reg, row_next;
    logic [9:0]  lc_reg, lc_next;
    logic [9:0]  gc_reg, gc_next;
    logic [9:0]  lr_reg, lr_next;
    logic [9:0]  gr_reg, gr_next;
    logic [10:0] w_eff, h_eff;
    logic [9:0]  w_last, h_last;
    logic [9:0]  x, y;
    logic [9:0]  lc_base, gc_base, lr_base, gr_base;
    logic        frame_start, last_col, last_row, accept;

    // frame size in effect
    always_comb
    begin
        if (cfg.frame_width < MIN_FRAME_SIZE)
            w_eff = MIN_FRAME_SIZE;
        else if (cfg.frame_width > W_TOP)
            w_eff = W_TOP;
        else
            w_eff = cfg.frame_width;
        if (cfg.frame_height < MIN_FRAME_SIZE)
            h_eff = MIN_FRAME_SIZE;
        else if (cfg.frame_height > H_TOP)
            h_eff = H_TOP;
        else
            h_eff = cfg.frame_height;
    end

    assign w_last = 10'(w_eff - 11'd1);
    assign h_last = 10'(h_eff - 11'd1);

    // position of this pixel, saturated when the frame shrank
    assign x = (col_reg > w_last) ? w_last : col_reg;
    assign y = (row_reg > h_last) ? h_last : row_reg;

    assign frame_start = (x == 10'd0) && (y == 10'd0);
    assign last_col    = (x == w_last);
    assign last_row    = (y == h_last);

    // tracked values restart at the first pixel of a frame
    assign lc_base = frame_start ? w_last : lc_reg;
    assign gc_base = frame_start ? 10'd0  : gc_reg;
    assign lr_base = frame_start ? h_last : lr_reg;
    assign gr_base = frame_start ? 10'd0  : gr_reg;

    // min and max updated independently
    always_comb
    begin
        lc_next = lc_base;
        gc_next = gc_base;
        lr_next = lr_base;
        gr_next = gr_base;
        if (foreground)
        begin
            if (x < lc_base) lc_next = x;
            if (x > gc_base) gc_next = x;
            if (y < lr_base) lr_next = y;
            if (y > gr_base) gr_next = y;
        end
    end

    // raster counters
    always_comb
    begin
        if (last_col)
        begin
            col_next = 10'd0;
            row_next = last_row ? 10'd0 : y + 10'd1;
        end
        else
        begin
            col_next = x + 10'd1;
            row_next = y;
        end
    end

    // pixels are held off only while the queue has no room
    assign in_ready  = rec_ready;
    assign accept    = in_valid && in_ready;
    assign rec_valid = accept && last_col && last_row;

    assign rec.least_col    = lc_next;
    assign rec.greatest_col = gc_next;
    assign rec.least_row    = lr_next;
    assign rec.greatest_row = gr_next;
    assign rec.size_w       = w_eff;
    assign rec.size_h       = h_eff;
    assign rec.pad          = cfg.crop_padding;

    // state update on each pixel transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 10'd0;
            row_reg <= 10'd0;
            lc_reg  <= 10'(RESET_FRAME_WIDTH - 11'd1);
            gc_reg  <= 10'd0;
            lr_reg  <= 10'(RESET_FRAME_HEIGHT - 11'd1);
            gr_reg  <= 10'd0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            lc_reg  <= lc_next;
            gc_reg  <= gc_next;
            lr_reg  <= lr_next;
            gr_reg  <= gr_next;
        end
    end

endmodule

FILE: sv/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Two-entry queue of frame records between the tracker and the window unit.
// ----------------------------------------------------------------------------
module bbc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bbc_pkg::frame_rec_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bbc_pkg::frame_rec_t pop_data
);
    import bbc_pkg::*;

    localparam int DEPTH = 2;

    frame_rec_t mem [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/bbc_window.sv
// ----------------------------------------------------------------------------
// bbc_window
// Back part: forms the padded, clamped crop window of a frame record and
// holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module bbc_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    output logic                rec_ready,
    input  bbc_pkg::frame_rec_t rec,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [9:0]          crop_x,
    output logic [9:0]          crop_y,
    output logic [9:0]          crop_width,
    output logic [9:0]          crop_height
);
    import bbc_pkg::*;

    // window along one axis from the tracked extremes
    function automatic axis_t form_axis(logic [9:0] lo, logic [9:0] hi,
                                        logic [10:0] size, logic [7:0] pad);
        logic [9:0]  last;
        logic [9:0]  a, b, s;
        logic [10:0] b_pad;
        axis_t       r;
        last  = 10'(size - 11'd1);
        a     = (lo > last) ? last : lo;
        b     = (hi > last) ? last : hi;
        s     = ({2'b00, pad} < a) ? a - {2'b00, pad} : 10'd0;
        b_pad = {1'b0, b} + {3'b000, pad};
        r.start = s;
        r.len   = (b_pad >= size) ? last - s : 10'(b_pad - {1'b0, s});
        return r;
    endfunction

    logic       out_valid_reg;
    logic       found_reg, found_next;
    logic [9:0] x_reg, y_reg, w_reg, h_reg;
    axis_t      ax_col, ax_row;
    logic       load;

    assign ax_col = form_axis(rec.least_col, rec.greatest_col, rec.size_w, rec.pad);
    assign ax_row = form_axis(rec.least_row, rec.greatest_row, rec.size_h, rec.pad);
    assign found_next = (rec.greatest_col != 10'd0) && (rec.greatest_row != 10'd0);

    // output register refills when empty or being drained
    assign rec_ready = !out_valid_reg || out_ready;
    assign load      = rec_valid && rec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rec_ready)
            out_valid_reg <= rec_valid;
    end

    // result payload, zero when no box
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= found_next;
            x_reg     <= found_next ? ax_col.start : 10'd0;
            w_reg     <= found_next ? ax_col.len   : 10'd0;
            y_reg     <= found_next ? ax_row.start : 10'd0;
            h_reg     <= found_next ? ax_row.len   : 10'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign crop_x      = x_reg;
    assign crop_y      = y_reg;
    assign crop_width  = w_reg;
    assign crop_height = h_reg;

endmodule

FILE: sv/binary_mask_bounding_box_crop.sv
// ----------------------------------------------------------------------------
// binary_mask_bounding_box_crop
// Bounding box of a binary mask in raster order, given as a padded crop window.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (in_valid/in_ready, foreground) takes one mask pixel per
//   transfer in raster order; column and row are counted from frame_width and
//   frame_height. Result channel (out_valid/out_ready) gives one crop window
//   per frame, after the frame's last pixel. Config channel (cfg_valid,
//   cfg_ready, cfg_index, cfg_data) writes frame_width, frame_height and
//   crop_padding; it is always ready and is to be used between frames.
// Throughput: one pixel per cycle while in_ready is high, set by the counter
//   and min/max update in the tracker, both done on each pixel transfer.
// Result path: after the last pixel transfer, the frame record is registered
//   in the frame record queue and then in the window output register.
// Stall: a stalled result holds in the output register; the tracker keeps
//   accepting pixels and in_ready drops only while the two-entry record queue
//   is full of finished frames.
// Reset: registers return to 160 x 120 with padding 30, counters clear and
//   the queue and output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_mask_bounding_box_crop #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        foreground,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [9:0]  crop_x,
    output logic [9:0]  crop_y,
    output logic [9:0]  crop_width,
    output logic [9:0]  crop_height,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import bbc_pkg::*;

    localparam int SIZE_W_TOP = (MAX_WIDTH  < 1024) ? MAX_WIDTH  : 1024;
    localparam int SIZE_H_TOP = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    cfg_t       cfg_reg;
    frame_rec_t push_rec, pop_rec;
    logic       push_valid, push_ready, pop_valid, pop_ready;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RESET_FRAME_WIDTH;
            cfg_reg.frame_height <= RESET_FRAME_HEIGHT;
            cfg_reg.crop_padding <= RESET_CROP_PADDING;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                CFG_CROP_PADDING: cfg_reg.crop_padding <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // front: pixel tracking
    bbc_tracker #(
        .SIZE_W_TOP (SIZE_W_TOP),
        .SIZE_H_TOP (SIZE_H_TOP)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .foreground (foreground),
        .rec_valid  (push_valid),
        .rec_ready  (push_ready),
        .rec        (push_rec)
    );

    // frame record queue
    bbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_rec)
    );

    // back: window forming and result register
    bbc_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (pop_valid),
        .rec_ready   (pop_ready),
        .rec         (pop_rec),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .crop_x      (crop_x),
        .crop_y      (crop_y),
        .crop_width  (crop_width),
        .crop_height (crop_height)
    );

endmodule

FILE: sv/bbc_checker.sv
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the crop block, bound to the top level.
// ----------------------------------------------------------------------------
module bbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       found,
    input logic [9:0] crop_x,
    input logic [9:0] crop_y,
    input logic [9:0] crop_width,
    input logic [9:0] crop_height
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(crop_x)
            && $stable(crop_y) && $stable(crop_width) && $stable(crop_height))
        else $error("result changed while stalled");

    // no box gives an all-zero window
    a_no_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> crop_x == 10'd0 && crop_y == 10'd0
            && crop_width == 10'd0 && crop_height == 10'd0)
        else $error("window not zero without a box");

    // window ends inside the largest frame
    a_window_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, crop_x} + {1'b0, crop_width}) < 11'd1024
            && ({1'b0, crop_y} + {1'b0, crop_height}) < 11'd1024)
        else $error("window runs past the frame edge");

    // no result right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind binary_mask_bounding_box_crop bbc_checker u_bbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .crop_x      (crop_x),
    .crop_y      (crop_y),
    .crop_width  (crop_width),
    .crop_height (crop_height)
);
